>>> src/frbc_pkg.sv
// Shared types and constants of the file read bucket cache.
package frbc_pkg;

	localparam int NUM_BUCKETS_DEF = 8;
	localparam int MAX_CHUNKS_DEF  = 64;

	// Configuration register indexes
	localparam logic REG_FILE_LENGTH = 1'b0;
	localparam logic REG_MAX_CACHE   = 1'b1;

	// Input commands and seek origins
	localparam logic       CMD_READ   = 1'b0;
	localparam logic       CMD_SEEK   = 1'b1;
	localparam logic [1:0] ORG_BEGIN  = 2'd0;
	localparam logic [1:0] ORG_CUR    = 2'd1;
	localparam logic [1:0] ORG_END    = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic clear;     // reopen the file
		logic cfg_we;    // load a register
		logic load;      // capture an input item
		logic setup;     // derive cache size and bucket size
		logic seek;      // apply a seek and form its result
		logic empty;     // form the empty-read result
		logic search;    // step the tag and victim scan
		logic chunk;     // update state and form a chunk result
	} frbc_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic is_seek;
		logic can_read;  // another chunk may be served
		logic scan_done;
		logic fin;       // the chunk just formed ends the request
	} frbc_sts_t;

endpackage

>>> src/frbc_datapath.sv
// Datapath: registers, bucket tables, scan and chunk arithmetic.
module frbc_datapath #(
	parameter int MAX_CHUNKS  = frbc_pkg::MAX_CHUNKS_DEF,
	localparam int NUM_BUCKETS = frbc_pkg::NUM_BUCKETS_DEF,
	localparam int BW = $clog2(NUM_BUCKETS),
	localparam int CW = $clog2(MAX_CHUNKS + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  frbc_pkg::frbc_cmd_t     cmd,
	output frbc_pkg::frbc_sts_t     sts,
	input  logic                    cfg_index,
	input  logic [31:0]             cfg_data,
	input  logic                    in_command,
	input  logic [1:0]              in_seek_origin,
	input  logic signed [32:0]      in_amount,
	output logic [2:0]              bucket_index,
	output logic [31:0]             bucket_offset,
	output logic [31:0]             chunk_bytes,
	output logic                    fetch,
	output logic [31:0]             fetch_offset,
	output logic [31:0]             fetch_bytes,
	output logic [31:0]             position,
	output logic [31:0]             total_bytes,
	output logic                    last
);

	localparam logic [1:0] ORG_BEGIN_C = frbc_pkg::ORG_BEGIN;
	localparam logic [1:0] ORG_CUR_C   = frbc_pkg::ORG_CUR;
	localparam logic [1:0] ORG_END_C   = frbc_pkg::ORG_END;

	logic [31:0] file_length_q, max_cache_q;
	logic [31:0] bucket_start_q [NUM_BUCKETS];
	logic [NUM_BUCKETS-1:0] bucket_valid_q;
	logic [31:0] last_use_q [NUM_BUCKETS];
	logic [31:0] use_counter_q, file_position_q;

	logic        command_q;
	logic [1:0]  origin_q;
	logic signed [32:0] amount_q;
	logic [31:0] bsize_q, left_q, total_q;
	logic        whole_q;
	logic [CW-1:0] nchunk_q;

	// scan state
	logic [BW-1:0] scan_q;
	logic          hit_q;
	logic [BW-1:0] hit_idx_q, vic_idx_q;
	logic [31:0]   vic_use_q;

	logic [31:0] cache_sz;
	logic [32:0] start_ext, end_ext;
	logic        in_range;
	logic [BW-1:0] sel;
	logic [31:0] new_start, lim, off, rem, cnt, new_pos;
	logic [CW-1:0] n_next;
	logic        scan_last;
	logic signed [34:0] np;

	assign cache_sz = (max_cache_q != 32'd0 && max_cache_q < file_length_q)
		? max_cache_q : file_length_q;

	// range test of the bucket under scan
	assign start_ext = {1'b0, bucket_start_q[scan_q]};
	assign end_ext   = start_ext + {1'b0, bsize_q};
	assign in_range  = bucket_valid_q[scan_q] &&
		({1'b0, file_position_q} >= start_ext) && ({1'b0, file_position_q} < end_ext);
	assign scan_last = whole_q || (scan_q == BW'(NUM_BUCKETS - 1));

	// chunk arithmetic for the chosen bucket
	assign sel = hit_q ? hit_idx_q : (whole_q ? '0 : vic_idx_q);
	assign lim = file_length_q - bsize_q;
	assign new_start = hit_q ? bucket_start_q[sel]
		: (whole_q ? 32'd0 : (file_position_q < lim ? file_position_q : lim));
	assign off = file_position_q - new_start;
	assign rem = bsize_q - off;
	assign cnt = left_q < rem ? left_q : rem;
	assign new_pos = file_position_q + cnt;
	assign n_next = nchunk_q + CW'(1);

	// seek target before clamping
	always_comb begin
		np = {3'b000, file_position_q};
		case (origin_q)
			ORG_BEGIN_C: np = 35'(amount_q);
			ORG_CUR_C:   np = {3'b000, file_position_q} + 35'(amount_q);
			ORG_END_C:   np = {3'b000, file_length_q} - 35'(amount_q);
			default:     np = {3'b000, file_position_q};
		endcase
	end

	assign sts.is_seek   = (command_q == frbc_pkg::CMD_SEEK);
	assign sts.can_read  = (left_q != 32'd0) && (file_position_q < file_length_q)
		&& (bsize_q != 32'd0) && (nchunk_q < CW'(MAX_CHUNKS));
	assign sts.scan_done = scan_last || in_range;
	assign sts.fin       = last;

	// control registers and tables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_length_q   <= '0;
			max_cache_q     <= '0;
			bucket_valid_q  <= '0;
			use_counter_q   <= '0;
			file_position_q <= '0;
			for (int i = 0; i < NUM_BUCKETS; i++) begin
				last_use_q[i] <= '0;
			end
		end else begin
			if (cmd.cfg_we) begin
				if (cfg_index == frbc_pkg::REG_FILE_LENGTH) file_length_q <= cfg_data;
				else max_cache_q <= cfg_data;
			end
			if (cmd.clear) begin
				bucket_valid_q  <= '0;
				use_counter_q   <= '0;
				file_position_q <= '0;
				for (int i = 0; i < NUM_BUCKETS; i++) begin
					last_use_q[i] <= '0;
				end
			end
			if (cmd.seek) begin
				if (np < 0) file_position_q <= '0;
				else if (np > $signed({3'b000, file_length_q})) file_position_q <= file_length_q;
				else file_position_q <= np[31:0];
			end
			if (cmd.chunk) begin
				bucket_valid_q[sel] <= 1'b1;
				use_counter_q       <= use_counter_q + 32'd1;
				last_use_q[sel]     <= use_counter_q + 32'd1;
				file_position_q     <= new_pos;
			end
		end
	end

	// bucket start table (reset to zero)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BUCKETS; i++) begin
				bucket_start_q[i] <= '0;
			end
		end else if (cmd.chunk && !hit_q) begin
			bucket_start_q[sel] <= new_start;
		end
	end

	// item capture, scan and result registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			command_q <= in_command;
			origin_q  <= in_seek_origin;
			amount_q  <= in_amount;
		end
		if (cmd.setup) begin
			whole_q  <= (cache_sz == file_length_q);
			bsize_q  <= (cache_sz == file_length_q) ? file_length_q
				: 32'(cache_sz / NUM_BUCKETS);
			left_q   <= amount_q[32] ? 32'd0 : amount_q[31:0];
			total_q  <= '0;
			nchunk_q <= '0;
			scan_q   <= '0;
			hit_q    <= 1'b0;
			vic_idx_q <= '0;
			vic_use_q <= last_use_q[0];
		end
		if (cmd.search) begin
			if (in_range) begin
				hit_q     <= 1'b1;
				hit_idx_q <= scan_q;
			end else if (last_use_q[scan_q] < vic_use_q) begin
				vic_idx_q <= scan_q;
				vic_use_q <= last_use_q[scan_q];
			end
			if (!scan_last) scan_q <= scan_q + BW'(1);
		end
		if (cmd.seek || cmd.empty) begin
			bucket_index  <= '0;
			bucket_offset <= '0;
			chunk_bytes   <= '0;
			fetch         <= 1'b0;
			fetch_offset  <= '0;
			fetch_bytes   <= '0;
			total_bytes   <= '0;
			last          <= 1'b1;
			position      <= cmd.seek
				? ((np < 0) ? 32'd0
				: (np > $signed({3'b000, file_length_q})) ? file_length_q : np[31:0])
				: file_position_q;
		end
		if (cmd.chunk) begin
			bucket_index  <= 3'(sel);
			bucket_offset <= off;
			chunk_bytes   <= cnt;
			fetch         <= !hit_q;
			fetch_offset  <= hit_q ? 32'd0 : new_start;
			fetch_bytes   <= hit_q ? 32'd0 : bsize_q;
			position      <= new_pos;
			total_bytes   <= total_q + cnt;
			last          <= (left_q == cnt) || (new_pos >= file_length_q)
				|| (n_next >= CW'(MAX_CHUNKS));
			left_q        <= left_q - cnt;
			total_q       <= total_q + cnt;
			nchunk_q      <= n_next;
			scan_q        <= '0;
			hit_q         <= 1'b0;
			vic_idx_q     <= '0;
			vic_use_q     <= (sel == '0) ? use_counter_q + 32'd1 : last_use_q[0];
		end
	end

endmodule

>>> src/frbc_ctrl.sv
// Controller state machine of the file read bucket cache.
module frbc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [31:0]         cfg_index,
	output frbc_pkg::frbc_cmd_t cmd,
	input  frbc_pkg::frbc_sts_t sts
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SETUP = 3'd1;
	localparam logic [2:0] ST_DISP  = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_CHUNK = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0] state_q, state_d;
	logic       fin_q, fin_d;

	// a pending register write takes the idle slot before an input item
	assign in_ready  = (state_q == ST_IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	// decode state into datapath commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		fin_d   = fin_q;
		case (state_q)
			ST_IDLE: begin
				if (cfg_valid) begin
					cmd.cfg_we = (cfg_index[31:1] == 31'd0);
					cmd.clear  = (cfg_index[31:1] == 31'd0);
				end else if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = ST_DISP;
			end
			ST_DISP: begin
				if (sts.is_seek) begin
					cmd.seek = 1'b1;
					fin_d    = 1'b1;
					state_d  = ST_OUT;
				end else if (sts.can_read) begin
					state_d = ST_SCAN;
				end else begin
					cmd.empty = 1'b1;
					fin_d     = 1'b1;
					state_d   = ST_OUT;
				end
			end
			ST_SCAN: begin
				cmd.search = 1'b1;
				if (sts.scan_done) state_d = ST_CHUNK;
			end
			ST_CHUNK: begin
				cmd.chunk = 1'b1;
				fin_d     = 1'b0;
				state_d   = ST_OUT;
			end
			ST_OUT: begin
				if (out_ready) state_d = (fin_q || sts.fin) ? ST_IDLE : ST_SCAN;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fin_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			fin_q   <= fin_d;
		end
	end

endmodule

>>> src/file_read_bucket_cache_core.sv
// Top level of the file read bucket cache: controller plus datapath.
// A read is split into chunks, one result transfer per chunk; each chunk costs
// a tag and LRU scan of one bucket per cycle (it stops at the first hit, covers
// all NUM_BUCKETS buckets on a miss and only bucket 0 in whole-file mode), an
// update state and an output state, and a read first passes through acceptance,
// setup and dispatch. A seek or empty read passes through acceptance, setup,
// dispatch and output. Output stalls hold the output state.
// One item is in work at a time; configuration writes are taken only while
// idle, win over a waiting input item and, to register 0 or 1, reopen the file.
module file_read_bucket_cache_core #(
	parameter int MAX_CHUNKS  = frbc_pkg::MAX_CHUNKS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [31:0]        cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               command,
	input  logic [1:0]         seek_origin,
	input  logic signed [32:0] amount,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         bucket_index,
	output logic [31:0]        bucket_offset,
	output logic [31:0]        chunk_bytes,
	output logic               fetch,
	output logic [31:0]        fetch_offset,
	output logic [31:0]        fetch_bytes,
	output logic [31:0]        position,
	output logic [31:0]        total_bytes,
	output logic               last
);

	frbc_pkg::frbc_cmd_t cmd;
	frbc_pkg::frbc_sts_t sts;

	frbc_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.cfg_valid, .cfg_ready, .cfg_index, .cmd, .sts
	);

	frbc_datapath #(.MAX_CHUNKS(MAX_CHUNKS)) u_dp (
		.clk, .arst_n, .cmd, .sts,
		.cfg_index(cfg_index[0]), .cfg_data,
		.in_command(command), .in_seek_origin(seek_origin), .in_amount(amount),
		.bucket_index, .bucket_offset, .chunk_bytes, .fetch, .fetch_offset,
		.fetch_bytes, .position, .total_bytes, .last
	);

endmodule

>>> src/frbc_checker.sv
// Port-level checker of the file read bucket cache, bound to the top level.
module frbc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        cfg_ready,
	input logic        fetch,
	input logic [31:0] chunk_bytes,
	input logic [31:0] fetch_bytes,
	input logic [31:0] total_bytes,
	input logic        last
);

	// no new item while a result waits
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");

	// a chunk never exceeds its refill
	a_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && fetch) |-> (chunk_bytes <= fetch_bytes))
		else $error("chunk larger than refill");

	// a non-final chunk is followed by another result, not idle
	a_more: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last) |=> !in_ready)
		else $error("request ended without final result");

	// a chunk carries bytes included in the running total
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && chunk_bytes != 32'd0) |-> (total_bytes >= chunk_bytes))
		else $error("running total below chunk size");

	// config port closed while busy
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !cfg_ready) else $error("config open while busy");

endmodule

bind file_read_bucket_cache_core frbc_checker u_frbc_checker (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cfg_ready,
	.fetch, .chunk_bytes, .fetch_bytes, .total_bytes, .last
);
